### hdl/mandelbrot_escape_time_macros.svh
// Assertion helpers shared by the escape-time RTL.
`ifndef MANDELBROT_ESCAPE_TIME_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MBE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MBE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/mbe_pkg.sv
package mbe_pkg;

  localparam int IMAGE_SIZE_DEF  = 1024;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int INT_BITS        = 4;
  localparam int ESCAPE_RADIUS   = 2;

  localparam logic [15:0] MAX_ITER_RST   = 16'd256;
  localparam logic [31:0] COORD_START_RST = 32'hE000_0000;
  localparam logic [30:0] STEP_RST       = 31'd1342177;
  localparam logic [10:0] HEIGHT_RST     = 11'd800;

  typedef enum logic [2:0] {
    REG_MAX_ITER     = 3'd0,
    REG_REAL_START   = 3'd1,
    REG_IMAG_START   = 3'd2,
    REG_REAL_STEP    = 3'd3,
    REG_IMAG_STEP    = 3'd4,
    REG_IMAGE_HEIGHT = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CR,
    S_CI,
    S_CIS,
    S_RR,
    S_II,
    S_CHK,
    S_UPD
  } state_t;

  typedef struct packed {
    logic [9:0] pixel_column;
    logic [9:0] pixel_row;
  } pixel_t;

  typedef struct packed {
    logic [15:0] iteration_count;
    logic        escaped;
    logic [9:0]  out_column;
    logic [9:0]  out_row;
  } result_t;

endpackage

### hdl/mandelbrot_escape_time.sv
// A pixel finishes after N iterations, or earlier when |z| leaves the radius-2 box;
// one shared multiplier forms zr*zr, zi*zi and zr*zi in turn for each iteration.
// Throughput: one pixel at a time; busy is low again in the cycle done pulses.
// Results are shown for one cycle under done and cannot be stalled.
// Reset (rst, synchronous) idles the sequencer and restores all register defaults.
`include "mandelbrot_escape_time_macros.svh"

module mandelbrot_escape_time import mbe_pkg::*; #(
  parameter int IMAGE_SIZE  = IMAGE_SIZE_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  pixel_t      pixel,
  output logic        done,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int FRAC_BITS = COORD_WIDTH - INT_BITS;
  localparam int OPW       = (COORD_WIDTH > 32) ? COORD_WIDTH : 32;
  localparam int PW        = 2 * OPW;

  localparam logic signed [PW-1:0] COORD_MAX =
    {{(PW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [PW-1:0] COORD_MIN =
    {{(PW-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};
  localparam logic [COORD_WIDTH:0] ESC_LIMIT =
    (COORD_WIDTH+1)'(ESCAPE_RADIUS) << FRAC_BITS;
  localparam logic [PW-1:0] ESC_THRESH =
    PW'(ESCAPE_RADIUS * ESCAPE_RADIUS) << (2 * FRAC_BITS);

  // configuration registers
  logic        [15:0] max_iterations;
  logic signed [31:0] real_start;
  logic signed [31:0] imag_start;
  logic        [30:0] real_step;
  logic        [30:0] imag_step;
  logic        [10:0] image_height;

  state_t state, state_next;

  logic        [9:0]             col_r;
  logic        [9:0]             row_r;
  logic        [15:0]            iter_cnt;
  logic signed [COORD_WIDTH-1:0] cr, ci, zr, zi;
  logic signed [PW-1:0]          prod, sq_r, sq_i;

  logic signed [OPW-1:0] mul_a, mul_b;
  logic signed [OPW-1:0] height_eff, row_off;
  logic        [15:0]    max_lim;
  logic                  cfg_wr;
  logic                  sq_esc;
  logic                  finish_chk;
  logic                  mag_esc;
  logic signed [COORD_WIDTH-1:0] zr_new, zi_new;

  function automatic logic signed [COORD_WIDTH-1:0] sat_coord(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] s;
    s = v;
    if (v > COORD_MAX) begin
      s = COORD_MAX;
    end else if (v < COORD_MIN) begin
      s = COORD_MIN;
    end
    return s[COORD_WIDTH-1:0];
  endfunction

  function automatic logic mag_ge_limit(input logic signed [COORD_WIDTH-1:0] v);
    logic signed [COORD_WIDTH:0] e;
    logic        [COORD_WIDTH:0] a;
    e = (COORD_WIDTH+1)'(v);
    a = (e < 0) ? -e : e;
    return a >= ESC_LIMIT;
  endfunction

  // ---------------------------------------------------------------- config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations <= MAX_ITER_RST;
      real_start     <= COORD_START_RST;
      imag_start     <= COORD_START_RST;
      real_step      <= STEP_RST;
      imag_step      <= STEP_RST;
      image_height   <= HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_MAX_ITER:     max_iterations <= pwdata[15:0];
        REG_REAL_START:   real_start     <= pwdata;
        REG_IMAG_START:   imag_start     <= pwdata;
        REG_REAL_STEP:    real_step      <= pwdata[30:0];
        REG_IMAG_STEP:    imag_step      <= pwdata[30:0];
        REG_IMAGE_HEIGHT: image_height   <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_MAX_ITER:     prdata = 32'(max_iterations);
      REG_REAL_START:   prdata = real_start;
      REG_IMAG_START:   prdata = imag_start;
      REG_REAL_STEP:    prdata = 32'(real_step);
      REG_IMAG_STEP:    prdata = 32'(imag_step);
      REG_IMAGE_HEIGHT: prdata = 32'(image_height);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- sequencer
  assign busy    = (state != S_IDLE);
  assign max_lim = (max_iterations == '0) ? 16'd1 : max_iterations;

  // flip the vertical axis; rows past the height give a negative offset
  assign height_eff = (OPW'(image_height) > OPW'(IMAGE_SIZE)) ? OPW'(IMAGE_SIZE)
                                                              : OPW'(image_height);
  assign row_off    = height_eff - OPW'(1) - OPW'(row_r);

  assign sq_esc     = $unsigned(sq_r + prod) >= ESC_THRESH;
  assign finish_chk = (iter_cnt != '0) && (sq_esc || (iter_cnt >= max_lim));

  assign zr_new  = sat_coord(((sq_r - sq_i) >>> FRAC_BITS) + PW'(cr));
  assign zi_new  = sat_coord(((prod <<< 1) >>> FRAC_BITS) + PW'(ci));
  assign mag_esc = mag_ge_limit(zr_new) || mag_ge_limit(zi_new);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_CR;
        end
      end
      S_CR: begin
        mul_a      = OPW'(col_r);
        mul_b      = OPW'(real_step);
        state_next = S_CI;
      end
      S_CI: begin
        mul_a      = row_off;
        mul_b      = OPW'(imag_step);
        state_next = S_CIS;
      end
      S_CIS: begin
        state_next = S_RR;
      end
      S_RR: begin
        mul_a      = OPW'(zr);
        mul_b      = OPW'(zr);
        state_next = S_II;
      end
      S_II: begin
        mul_a      = OPW'(zi);
        mul_b      = OPW'(zi);
        state_next = S_CHK;
      end
      S_CHK: begin
        mul_a      = OPW'(zr);
        mul_b      = OPW'(zi);
        state_next = finish_chk ? S_IDLE : S_UPD;
      end
      S_UPD: begin
        state_next = mag_esc ? S_IDLE : S_RR;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          col_r    <= pixel.pixel_column;
          row_r    <= pixel.pixel_row;
          iter_cnt <= '0;
        end
      end
      S_CI: cr <= sat_coord(PW'(real_start) + prod);
      S_CIS: begin
        ci       <= sat_coord(PW'(imag_start) + prod);
        zr       <= '0;
        zi       <= '0;
      end
      S_II:  sq_r <= prod;
      S_CHK: sq_i <= prod;
      S_UPD: begin
        zr       <= zr_new;
        zi       <= zi_new;
        iter_cnt <= iter_cnt + 16'd1;
      end
      default: ;
    endcase
  end

  // result register; one-cycle strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (state == S_CHK && finish_chk) begin
        done <= 1'b1;
      end else if (state == S_UPD && mag_esc) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CHK && finish_chk) begin
      result.iteration_count <= iter_cnt;
      result.escaped         <= sq_esc;
      result.out_column      <= col_r;
      result.out_row         <= row_r;
    end else if (state == S_UPD && mag_esc) begin
      result.iteration_count <= iter_cnt + 16'd1;
      result.escaped         <= 1'b1;
      result.out_column      <= col_r;
      result.out_row         <= row_r;
    end
  end

  // ---------------------------------------------------------------- checks
  `MBE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request accepted but sequencer idle")
  `MBE_ASSERT_SAME(a_done_src, done, $past(state) == S_CHK || $past(state) == S_UPD, "stray done")
  `MBE_ASSERT_SAME(a_limit_cnt, done && !result.escaped, result.iteration_count == max_lim, "bad count")
  `MBE_ASSERT_SAME(a_cnt_bound, busy, iter_cnt <= max_lim, "iteration count overran limit")

endmodule
